### sv/ccmp_pkg.sv
package ccmp_pkg;

    // Geometry of the cell stores
    localparam int CELL_COUNT = 4096;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int STAMP_W    = 32;
    localparam int IDX_W      = 12;
    localparam int COST_W     = 8;
    localparam int TIME_W     = 32;

    // Touched marks are kept as a begin-epoch tag per cell; tag 0 means never touched
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    // Request codes
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_MERGE = 2'd1;
    localparam logic [1:0] REQ_FINAL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [COST_W-1:0] MIN_COST_RST = 8'd1;
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd8000;

    // Cost scaling: floor(v * 252 / 100) == (v * 1321236) >> 19 for v in 0..100
    localparam logic [6:0]        GRID_MAX  = 7'd100;
    localparam logic [COST_W-1:0] COST_MAX  = 8'd252;
    localparam int                SCALE_MUL = 1321236;
    localparam int                SCALE_SH  = 19;
    localparam int                PROD_W    = 28;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  cell_index;
        logic              in_grid;
        logic signed [7:0] grid_value;
        logic [COST_W-1:0] master_cost;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              write_enable;
        logic [COST_W-1:0] new_cost;
        logic [IDX_W-1:0]  out_index;
    } t_out_item;

    // One word of the main cell store
    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [STAMP_W-1:0] stamp;
        logic               owned;
    } t_cell_word;

    localparam int CELL_WORD_W = $bits(t_cell_word);

    // Controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               commit;
        logic               clr_main;
        logic               clr_tag;
        logic [CELL_AW-1:0] clr_addr;
        logic [EPOCH_W-1:0] epoch;
    } t_dp_cmd;

endpackage

### sv/ccmp_ram.sv
module ccmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ccmp_ctrl.sv
module ccmp_ctrl
    import ccmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TAGCLR
    } t_state;

    t_state             r_state, n_state;
    logic [CELL_AW-1:0] r_sweep, n_sweep;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_out_valid, n_out_valid;

    logic w_accept;
    logic w_commit;
    logic w_sweep_end;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_sweep_end = (r_sweep == CELL_AW'(CELL_COUNT - 1));

    // Next state
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_epoch     = r_epoch;
        n_out_valid = r_out_valid;

        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR, S_TAGCLR: begin
                n_sweep = r_sweep + CELL_AW'(1);
                if (w_sweep_end) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_BEGIN) begin
                        // new epoch retires all touched marks; wrap needs a tag sweep
                        if (r_epoch == EPOCH_LAST) begin
                            n_epoch = EPOCH_FIRST;
                            n_sweep = '0;
                            n_state = S_TAGCLR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end else if (i_req_type == REQ_MERGE || i_req_type == REQ_FINAL) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.load     = w_accept && (i_req_type == REQ_MERGE || i_req_type == REQ_FINAL);
        o_cmd.commit   = w_commit;
        o_cmd.clr_main = (r_state == S_CLEAR);
        o_cmd.clr_tag  = (r_state == S_CLEAR) || (r_state == S_TAGCLR);
        o_cmd.clr_addr = r_sweep;
        o_cmd.epoch    = r_epoch;
    end

    assign o_out_valid = r_out_valid;

endmodule

### sv/ccmp_dp.sv
module ccmp_dp
    import ccmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_item
);

    // Configuration registers
    logic              r_persist;
    logic [COST_W-1:0] r_min_cost;
    logic [TIME_W-1:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist  <= 1'b0;
            r_min_cost <= MIN_COST_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERSIST:  r_persist  <= i_cfg_data[0];
                CFG_MIN_COST: r_min_cost <= i_cfg_data[COST_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Item register
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_item;
        end
    end

    // Cell stores: main word and touched-epoch tag
    logic [CELL_AW-1:0]     w_raddr;
    logic [CELL_AW-1:0]     w_waddr;
    logic [CELL_WORD_W-1:0] w_main_rdata;
    logic [EPOCH_W-1:0]     w_tag_rdata;
    logic                   w_main_we, w_tag_we;
    t_cell_word             w_main_wdata;
    logic [EPOCH_W-1:0]     w_tag_wdata;

    assign w_raddr = CELL_AW'(i_in_item.cell_index);

    ccmp_ram #(
        .WIDTH (CELL_WORD_W),
        .DEPTH (CELL_COUNT)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (w_main_we),
        .i_waddr (w_waddr),
        .i_wdata (w_main_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (w_raddr),
        .o_rdata (w_main_rdata)
    );

    ccmp_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (CELL_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_waddr),
        .i_wdata (w_tag_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_rdata)
    );

    // Cell update
    t_cell_word         w_rd;
    logic               w_touched;
    logic               w_in_range;
    logic [STAMP_W-1:0] w_now;
    logic [STAMP_W-1:0] w_age;
    logic               w_live;
    logic [6:0]         w_v;
    logic [PROD_W-1:0]  w_prod;
    logic [COST_W-1:0]  w_scaled;
    logic [COST_W-1:0]  w_minc;
    t_cell_word         w_new;
    logic               w_upd_main;
    logic               w_upd_tag;
    logic               w_write;
    logic [COST_W-1:0]  w_cost;

    assign w_rd       = t_cell_word'(w_main_rdata);
    assign w_touched  = (w_tag_rdata == i_cmd.epoch);
    assign w_in_range = 32'(r_in.cell_index) < 32'(CELL_COUNT);
    assign w_now      = STAMP_W'(r_in.now_ms);
    assign w_age      = w_now - w_rd.stamp;
    // a stamp later than now counts as live
    assign w_live     = (w_rd.stamp != '0) &&
                        ((w_now <= w_rd.stamp) || (w_age <= STAMP_W'(r_timeout)));
    assign w_v        = (r_in.grid_value > $signed({1'b0, GRID_MAX})) ? GRID_MAX
                                                                      : r_in.grid_value[6:0];
    assign w_prod     = PROD_W'(w_v) * PROD_W'(SCALE_MUL);
    assign w_scaled   = COST_W'(w_prod >> SCALE_SH);
    assign w_minc     = (r_min_cost > COST_MAX) ? COST_MAX : r_min_cost;

    always_comb begin
        w_new      = w_rd;
        w_upd_main = 1'b0;
        w_upd_tag  = 1'b0;
        w_write    = 1'b0;
        w_cost     = '0;
        if (w_in_range) begin
            if (r_in.req_type == REQ_MERGE) begin
                if (!r_in.in_grid) begin
                    // outside the grid: replay a live persisted cost
                    if (r_persist && w_live) begin
                        w_write    = (r_in.master_cost != w_rd.cost);
                        w_cost     = w_rd.cost;
                        w_new.owned = 1'b1;
                        w_upd_main = 1'b1;
                        w_upd_tag  = 1'b1;
                    end
                end else if (r_in.grid_value == 8'sd0) begin
                    // clear: release an owned cell
                    w_upd_tag = 1'b1;
                    if (w_rd.owned) begin
                        w_write     = (r_in.master_cost == w_rd.cost);
                        w_new.owned = 1'b0;
                        w_new.stamp = '0;
                        w_upd_main  = 1'b1;
                    end
                end else if (!r_in.grid_value[7]) begin
                    // cost: persist the scaled value
                    if (!r_persist || (w_scaled >= w_minc)) begin
                        if (r_persist) begin
                            w_new.stamp = w_now;
                        end
                        w_new.cost  = w_scaled;
                        w_new.owned = 1'b1;
                        w_upd_main  = 1'b1;
                        w_upd_tag   = 1'b1;
                        w_write     = (r_in.master_cost != w_scaled);
                        w_cost      = w_scaled;
                    end
                end
            end else if (w_rd.owned && !w_touched) begin
                // finalize: free an owned cell left untouched
                w_write     = (r_in.master_cost == w_rd.cost);
                w_new.owned = 1'b0;
                w_new.stamp = '0;
                w_new.cost  = '0;
                w_upd_main  = 1'b1;
            end
        end
    end

    // Store write ports: clearing sweep or item commit
    always_comb begin
        if (i_cmd.clr_tag) begin
            w_waddr      = i_cmd.clr_addr;
            w_main_we    = i_cmd.clr_main;
            w_tag_we     = 1'b1;
            w_main_wdata = '0;
            w_tag_wdata  = '0;
        end else begin
            w_waddr      = CELL_AW'(r_in.cell_index);
            w_main_we    = i_cmd.commit && w_upd_main;
            w_tag_we     = i_cmd.commit && w_upd_tag;
            w_main_wdata = w_new;
            w_tag_wdata  = i_cmd.epoch;
        end
    end

    // Result register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.write_enable <= w_write;
            r_out.new_cost     <= w_write ? w_cost : '0;
            r_out.out_index    <= r_in.cell_index;
        end
    end

    assign o_out_item = r_out;

endmodule

### sv/costmap_cell_merge_persist.sv
// Costmap cell merge with persistence. Each begin item (req_type 0) gives no
// result; each merge or finalize item gives one result. Such an item first
// reads the cell's word from the cell stores, whose read port is registered,
// then updates it and loads the result register, which waits while an earlier
// result is still held on the output; no new item is taken until that load.
// After reset the input is held off while the cell stores are cleared one
// entry per cycle, and every 255th begin item is followed by a further sweep
// that clears the per-cell touched tags. Configuration writes are taken in
// every cycle. Request type 3 is dropped.
module costmap_cell_merge_persist
    import ccmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;

    ccmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_in_item.req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    ccmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule
